[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPLIES(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("%m: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("%m: next-cycle check failed");

`endif

[src/asot_pkg.sv]
package asot_pkg;

	localparam int COORD_BITS = 24;
	localparam int AXES       = 3;
	localparam int MAG_BITS   = COORD_BITS + 1;
	localparam int SQ_BITS    = 2 * MAG_BITS;
	localparam int SUM_BITS   = SQ_BITS + 2;
	localparam int CFG_IDX_BITS = 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic        [COORD_BITS-1:0] cfg_data_t;
	typedef logic signed [COORD_BITS:0]   diff_t;
	typedef logic        [MAG_BITS-1:0]   mag_t;
	typedef logic        [SQ_BITS-1:0]    sq_t;
	typedef logic        [SUM_BITS-1:0]   sum_t;
	typedef logic signed [COORD_BITS+1:0] gap_t;
	typedef logic        [COORD_BITS+1:0] gmag_t;
	typedef logic        [1:0]            kind_t;
	typedef logic        [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam kind_t KIND_POINT = 2'd0;
	localparam kind_t KIND_HOLDS = 2'd1;
	localparam kind_t KIND_MEETS = 2'd2;

	localparam cfg_idx_t CFG_IS_SPHERE = 3'd0;
	localparam cfg_idx_t CFG_A_X       = 3'd1;
	localparam cfg_idx_t CFG_A_Y       = 3'd2;
	localparam cfg_idx_t CFG_A_Z       = 3'd3;
	localparam cfg_idx_t CFG_B_X       = 3'd4;
	localparam cfg_idx_t CFG_B_Y       = 3'd5;
	localparam cfg_idx_t CFG_B_Z       = 3'd6;

	typedef enum logic [1:0] {
		MODE_FLAG,
		MODE_LE1,
		MODE_LE2,
		MODE_LT1
	} mode_t;

	function automatic diff_t sub(coord_t a, coord_t b);
		return diff_t'(a) - diff_t'(b);
	endfunction

	function automatic mag_t mag_of(diff_t d);
		return d[COORD_BITS] ? mag_t'(-d) : mag_t'(d);
	endfunction

	function automatic logic in_axis(coord_t p, coord_t lo, coord_t hi);
		return !(p < lo || p > hi);
	endfunction

	function automatic coord_t clamp(coord_t c, coord_t lo, coord_t hi);
		coord_t t;
		t = (c < hi) ? c : hi;
		return (lo > t) ? lo : t;
	endfunction

	function automatic logic rim_clear(coord_t lo, coord_t hi, coord_t c, coord_t rad);
		return rad[COORD_BITS-1] ||
			((mag_of(sub(hi, c)) >= mag_t'(rad)) && (mag_of(sub(c, lo)) >= mag_t'(rad)));
	endfunction

	function automatic logic boxes_meet(coord_t ra, coord_t rb, coord_t oa, coord_t ob);
		gap_t  gap;
		gap_t  span;
		gmag_t gm;
		gap  = (gap_t'(ra) + gap_t'(rb)) - (gap_t'(oa) + gap_t'(ob));
		span = (gap_t'(rb) - gap_t'(ra)) + (gap_t'(ob) - gap_t'(oa));
		gm   = gap[COORD_BITS+1] ? gmag_t'(-gap) : gmag_t'(gap);
		return !span[COORD_BITS+1] && !(gm > gmag_t'(span));
	endfunction

endpackage

[src/aabb_sphere_overlap_test.sv]
// Region overlap test, box or sphere reference against box, sphere or point.
// Result path: input, operand, square and result registers (squares run
// on seven parallel 25x25 multipliers).
// Throughput: one query per cycle; a stalled output backs up the pipeline.
// Reset: clears the reference region to a box at the origin and empties the pipeline.
`include "assert_macros.svh"

module aabb_sphere_overlap_test (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  asot_pkg::cfg_idx_t  cfg_idx,
	input  asot_pkg::cfg_data_t cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  asot_pkg::kind_t     kind,
	input  logic                other_is_sphere,
	input  asot_pkg::coord_t    other_a_x,
	input  asot_pkg::coord_t    other_a_y,
	input  asot_pkg::coord_t    other_a_z,
	input  asot_pkg::coord_t    other_b_x,
	input  asot_pkg::coord_t    other_b_y,
	input  asot_pkg::coord_t    other_b_z,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                hit
);
	import asot_pkg::*;

	logic   ref_is_sphere_q;
	coord_t ref_a_q [AXES];
	coord_t ref_b_q [AXES];

	logic   v_s1, v_s2, v_s3, v_s4;
	logic   en_s1, en_s2, en_s3, en_s4;

	kind_t  kind_s1;
	logic   other_is_sphere_s1;
	coord_t oa_s1 [AXES];
	coord_t ob_s1 [AXES];

	mode_t  mode_s2;
	logic   flag_s2;
	mag_t   m0_s2 [AXES];
	mag_t   m1_s2 [AXES];
	mag_t   mt_s2;

	mode_t  mode_s3;
	logic   flag_s3;
	sq_t    sq0_s3 [AXES];
	sq_t    sq1_s3 [AXES];
	sq_t    sqt_s3;

	logic   hit_s4;

	mode_t  mode_c;
	logic   flag_c;
	mag_t   m0_c [AXES];
	mag_t   m1_c [AXES];
	mag_t   mt_c;
	logic   inbox_a, inbox_b, rim_ok, bb_ok;
	mag_t   dc_a [AXES];
	mag_t   dc_b [AXES];
	mag_t   near_r [AXES];
	mag_t   near_o [AXES];
	diff_t  room, reach;

	sum_t   d0_c, d1_c, t_c;
	logic   hit_c;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_is_sphere_q <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				ref_a_q[i] <= '0;
				ref_b_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_IS_SPHERE: ref_is_sphere_q <= cfg_wdata[0];
				CFG_A_X:       ref_a_q[0] <= $signed(cfg_wdata);
				CFG_A_Y:       ref_a_q[1] <= $signed(cfg_wdata);
				CFG_A_Z:       ref_a_q[2] <= $signed(cfg_wdata);
				CFG_B_X:       ref_b_q[0] <= $signed(cfg_wdata);
				CFG_B_Y:       ref_b_q[1] <= $signed(cfg_wdata);
				CFG_B_Z:       ref_b_q[2] <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	// stall chain: a stage loads when empty or when the next one loads
	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			kind_s1            <= kind;
			other_is_sphere_s1 <= other_is_sphere;
			oa_s1[0] <= other_a_x;
			oa_s1[1] <= other_a_y;
			oa_s1[2] <= other_a_z;
			ob_s1[0] <= other_b_x;
			ob_s1[1] <= other_b_y;
			ob_s1[2] <= other_b_z;
		end
	end

	// operand selection and the box-only tests
	always_comb begin
		inbox_a = 1'b1;
		inbox_b = 1'b1;
		rim_ok  = 1'b1;
		bb_ok   = 1'b1;
		for (int i = 0; i < AXES; i++) begin
			inbox_a = inbox_a && in_axis(oa_s1[i], ref_a_q[i], ref_b_q[i]);
			inbox_b = inbox_b && in_axis(ob_s1[i], ref_a_q[i], ref_b_q[i]);
			rim_ok  = rim_ok && rim_clear(ref_a_q[i], ref_b_q[i], oa_s1[i], ob_s1[0]);
			bb_ok   = bb_ok && boxes_meet(ref_a_q[i], ref_b_q[i], oa_s1[i], ob_s1[i]);
			dc_a[i]   = mag_of(sub(ref_a_q[i], oa_s1[i]));
			dc_b[i]   = mag_of(sub(ref_a_q[i], ob_s1[i]));
			near_r[i] = mag_of(sub(clamp(ref_a_q[i], oa_s1[i], ob_s1[i]), ref_a_q[i]));
			near_o[i] = mag_of(sub(clamp(oa_s1[i], ref_a_q[i], ref_b_q[i]), oa_s1[i]));
		end
		room  = sub(ref_b_q[0], ob_s1[0]);
		reach = diff_t'(ref_b_q[0]) + diff_t'(ob_s1[0]);

		mode_c = MODE_FLAG;
		flag_c = 1'b0;
		m0_c   = dc_a;
		m1_c   = dc_b;
		mt_c   = mag_of(diff_t'(ref_b_q[0]));

		unique case (kind_s1)
			KIND_POINT: begin
				if (ref_is_sphere_q) mode_c = MODE_LE1;
				else flag_c = inbox_a;
			end
			KIND_HOLDS: begin
				if (!other_is_sphere_s1) begin
					if (ref_is_sphere_q) mode_c = MODE_LE2;
					else flag_c = inbox_a && inbox_b;
				end else if (ref_is_sphere_q) begin
					if (!room[COORD_BITS] && room != '0) begin
						mode_c = MODE_LT1;
						mt_c   = mag_t'(room);
					end
				end else begin
					flag_c = inbox_a && rim_ok;
				end
			end
			KIND_MEETS: begin
				if (!ref_is_sphere_q && !other_is_sphere_s1) begin
					flag_c = bb_ok;
				end else if (ref_is_sphere_q && other_is_sphere_s1) begin
					if (!reach[COORD_BITS] && reach != '0) begin
						mode_c = MODE_LT1;
						mt_c   = mag_t'(reach);
					end
				end else if (ref_is_sphere_q) begin
					mode_c = MODE_LT1;
					m0_c   = near_r;
				end else begin
					mode_c = MODE_LT1;
					m0_c   = near_o;
					mt_c   = mag_of(diff_t'(ob_s1[0]));
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			mode_s2 <= mode_c;
			flag_s2 <= flag_c;
			m0_s2   <= m0_c;
			m1_s2   <= m1_c;
			mt_s2   <= mt_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			mode_s3 <= mode_s2;
			flag_s3 <= flag_s2;
			for (int i = 0; i < AXES; i++) begin
				sq0_s3[i] <= sq_t'(m0_s2[i]) * sq_t'(m0_s2[i]);
				sq1_s3[i] <= sq_t'(m1_s2[i]) * sq_t'(m1_s2[i]);
			end
			sqt_s3 <= sq_t'(mt_s2) * sq_t'(mt_s2);
		end
	end

	// squared distance against squared limit, or the flag chosen earlier
	always_comb begin
		d0_c = sum_t'(sq0_s3[0]) + sum_t'(sq0_s3[1]) + sum_t'(sq0_s3[2]);
		d1_c = sum_t'(sq1_s3[0]) + sum_t'(sq1_s3[1]) + sum_t'(sq1_s3[2]);
		t_c  = sum_t'(sqt_s3);
		unique case (mode_s3)
			MODE_FLAG: hit_c = flag_s3;
			MODE_LE1:  hit_c = (d0_c <= t_c);
			MODE_LE2:  hit_c = (d0_c <= t_c) && (d1_c <= t_c);
			MODE_LT1:  hit_c = (d0_c < t_c);
			default:   hit_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s4) hit_s4 <= hit_c;
	end

	assign out_valid = v_s4;
	assign hit       = hit_s4;

	`ASSERT_IMPLIES(a_room_means_ready, ($countones({v_s1, v_s2, v_s3, v_s4}) < 4), in_ready)
	`ASSERT_IMPLIES(a_full_stall_blocks, (v_s1 && v_s2 && v_s3 && v_s4 && !out_ready), !in_ready)
	`ASSERT_NEXT(a_s3_reaches_out, (v_s3 && en_s4), out_valid)

endmodule

[tb/tb_aabb_sphere_overlap_test.sv]
module tb_aabb_sphere_overlap_test;
	timeunit 1ns;
	timeprecision 1ps;

	import asot_pkg::*;

	localparam kind_t    KIND_NONE  = 2'd3;
	localparam cfg_idx_t CFG_UNUSED = 3'd7;

	localparam int LATENCY      = 3;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int NUM_PHASES   = 11;
	localparam int PHASE_ITEMS  = 125;
	localparam int HOLD_ITEMS   = 40;
	localparam int HOLD_CYCLES  = 48;

	localparam coord_t C_MAX = 24'sh7FFFFF;
	localparam coord_t C_MIN = 24'sh800000;
	localparam coord_t CZ    = 24'sd0;
	localparam coord_t CEPS  = 24'sd1;
	localparam coord_t CP1   = 24'sd256;
	localparam coord_t CN1   = -24'sd256;
	localparam coord_t CP1U  = 24'sd257;
	localparam coord_t CP1D  = 24'sd255;
	localparam coord_t CP2   = 24'sd512;
	localparam coord_t CN2   = -24'sd512;
	localparam coord_t CP4   = 24'sd1024;

	typedef struct packed {
		logic   sph;
		coord_t ax, ay, az;
		coord_t bx, by, bz;
	} zone_t;

	typedef struct packed {
		kind_t kind;
		zone_t zone;
	} query_t;

	typedef struct packed {
		logic [1:0] sel;
		query_t     q;
		logic       known;
		logic       val;
	} dir_row_t;

	typedef longint vec3_t [3];

	typedef struct {
		bit    sph;
		vec3_t a;
		vec3_t b;
	} shape_t;

	logic      clk;
	logic      arst_n          = 1'b0;
	logic      cfg_we          = 1'b0;
	cfg_idx_t  cfg_idx         = '0;
	cfg_data_t cfg_wdata       = '0;
	logic      in_valid        = 1'b0;
	logic      in_ready;
	kind_t     kind            = KIND_POINT;
	logic      other_is_sphere = 1'b0;
	coord_t    other_a_x       = '0;
	coord_t    other_a_y       = '0;
	coord_t    other_a_z       = '0;
	coord_t    other_b_x       = '0;
	coord_t    other_b_y       = '0;
	coord_t    other_b_z       = '0;
	logic      out_valid;
	logic      out_ready       = 1'b0;
	logic      hit;

	aabb_sphere_overlap_test u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.other_is_sphere (other_is_sphere),
		.other_a_x       (other_a_x),
		.other_a_y       (other_a_y),
		.other_a_z       (other_a_z),
		.other_b_x       (other_b_x),
		.other_b_y       (other_b_y),
		.other_b_z       (other_b_z),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.hit             (hit)
	);

	zone_t dir_anchors [4] = '{
		'{1'b0, CZ, CZ, CZ, CZ, CZ, CZ},
		'{1'b0, CN1, CN1, CN1, CP1, CP1, CP1},
		'{1'b1, CZ, CZ, CZ, CP2, CN1, CP1},
		'{1'b1, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX}
	};

	dir_row_t dir_rows [25] = '{
		'{2'd0, '{KIND_POINT, '{1'b0, CZ, CZ, CZ, CZ, CZ, CZ}}, 1'b1, 1'b1},
		'{2'd0, '{KIND_POINT, '{1'b1, CEPS, CZ, CZ, C_MAX, C_MIN, C_MAX}}, 1'b1, 1'b0},
		'{2'd0, '{KIND_NONE, '{1'b1, CZ, CZ, CZ, C_MAX, C_MAX, C_MAX}}, 1'b1, 1'b0},
		'{2'd0, '{KIND_MEETS, '{1'b0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX}}, 1'b0, 1'b0},
		'{2'd0, '{KIND_HOLDS, '{1'b0, CZ, CZ, CZ, CZ, CZ, CZ}}, 1'b1, 1'b1},
		'{2'd1, '{KIND_POINT, '{1'b0, CP1, CP1, CP1, CZ, CZ, CZ}}, 1'b1, 1'b1},
		'{2'd1, '{KIND_POINT, '{1'b0, CP1U, CZ, CZ, CZ, CZ, CZ}}, 1'b1, 1'b0},
		'{2'd1, '{KIND_HOLDS, '{1'b0, CN1, CN1, CN1, CP1, CP1, CP1}}, 1'b0, 1'b0},
		'{2'd1, '{KIND_HOLDS, '{1'b1, CZ, CZ, CZ, CP1, CZ, CZ}}, 1'b0, 1'b0},
		'{2'd1, '{KIND_HOLDS, '{1'b1, CZ, CZ, CZ, CP1U, CZ, CZ}}, 1'b0, 1'b0},
		'{2'd1, '{KIND_HOLDS, '{1'b1, CP1D, CZ, CZ, CN2, CZ, CZ}}, 1'b0, 1'b0},
		'{2'd1, '{KIND_MEETS, '{1'b0, CP1, CN1, CN1, CP2, CP1, CP1}}, 1'b0, 1'b0},
		'{2'd1, '{KIND_MEETS, '{1'b1, CP2, CZ, CZ, CP1, CZ, CZ}}, 1'b0, 1'b0},
		'{2'd1, '{KIND_MEETS, '{1'b0, CP1, CP1, CP1, CN1, CN1, CN1}}, 1'b0, 1'b0},
		'{2'd2, '{KIND_POINT, '{1'b0, CP2, CZ, CZ, CZ, CZ, CZ}}, 1'b1, 1'b1},
		'{2'd2, '{KIND_HOLDS, '{1'b1, CZ, CZ, CZ, CP2, CZ, CZ}}, 1'b1, 1'b0},
		'{2'd2, '{KIND_HOLDS, '{1'b1, CP1, CZ, CZ, CP1D, CZ, CZ}}, 1'b0, 1'b0},
		'{2'd2, '{KIND_HOLDS, '{1'b0, CN1, CN1, CN1, CP1, CP1, CP1}}, 1'b0, 1'b0},
		'{2'd2, '{KIND_MEETS, '{1'b1, CP4, CZ, CZ, CP2, CZ, CZ}}, 1'b0, 1'b0},
		'{2'd2, '{KIND_MEETS, '{1'b1, CZ, CZ, CZ, CN2, CZ, CZ}}, 1'b1, 1'b0},
		'{2'd2, '{KIND_MEETS, '{1'b0, CP2, CP2, CP2, CP4, CP4, CP4}}, 1'b0, 1'b0},
		'{2'd3, '{KIND_POINT, '{1'b0, C_MAX, C_MAX, C_MAX, CZ, CZ, CZ}}, 1'b0, 1'b0},
		'{2'd3, '{KIND_MEETS, '{1'b1, C_MAX, C_MAX, C_MAX, C_MAX, CZ, CZ}}, 1'b0, 1'b0},
		'{2'd3, '{KIND_HOLDS, '{1'b0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX}}, 1'b0, 1'b0},
		'{2'd3, '{KIND_NONE, '{1'b0, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX}}, 1'b1, 1'b0}
	};

	zone_t anchor_zone = '0;
	bit    pending_hits [$];
	bit    want_hit;
	bit    calm        = 1'b0;
	bit    hold_out    = 1'b0;
	bit    tx_choppy   = 1'b0;
	int    tx_left     = 0;
	int    errors      = 0;
	int    cycle_count = 0;
	int    results_seen = 0;
	int    hits_seen   = 0;
	int    anchors_loaded = 0;
	int    kind_count [4] = '{0, 0, 0, 0};

	function automatic longint widen(coord_t c);
		return longint'(c);
	endfunction

	function automatic longint absv(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic shape_t to_shape(zone_t z);
		shape_t s;
		s.sph  = z.sph;
		s.a[0] = widen(z.ax);
		s.a[1] = widen(z.ay);
		s.a[2] = widen(z.az);
		s.b[0] = widen(z.bx);
		s.b[1] = widen(z.by);
		s.b[2] = widen(z.bz);
		return s;
	endfunction

	function automatic longint dist_sq(vec3_t p, vec3_t q);
		return (p[0] - q[0]) * (p[0] - q[0]) + (p[1] - q[1]) * (p[1] - q[1]) +
			(p[2] - q[2]) * (p[2] - q[2]);
	endfunction

	function automatic bit point_in(shape_t r, vec3_t p);
		if (r.sph) begin
			return dist_sq(r.a, p) <= r.b[0] * r.b[0];
		end
		for (int i = 0; i < 3; i++) begin
			if (p[i] < r.a[i] || p[i] > r.b[i])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit encloses(shape_t r, shape_t o);
		longint room;
		if (!o.sph)
			return point_in(r, o.a) && point_in(r, o.b);
		if (r.sph) begin
			room = r.b[0] - o.b[0];
			if (room <= 0)
				return 1'b0;
			return dist_sq(r.a, o.a) < room * room;
		end
		if (!point_in(r, o.a))
			return 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (absv(r.b[i] - o.a[i]) < o.b[0] || absv(o.a[i] - r.a[i]) < o.b[0])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit ball_touches_box(shape_t s, shape_t bx);
		vec3_t  near_pt;
		longint t;
		for (int i = 0; i < 3; i++) begin
			t = (s.a[i] < bx.b[i]) ? s.a[i] : bx.b[i];
			near_pt[i] = (bx.a[i] > t) ? bx.a[i] : t;
		end
		return dist_sq(near_pt, s.a) < s.b[0] * s.b[0];
	endfunction

	function automatic bit touches(shape_t r, shape_t o);
		longint gap;
		longint span;
		longint reach;
		if (!r.sph && !o.sph) begin
			for (int i = 0; i < 3; i++) begin
				gap  = (r.a[i] + r.b[i]) - (o.a[i] + o.b[i]);
				span = (r.b[i] - r.a[i]) + (o.b[i] - o.a[i]);
				if (absv(gap) > span)
					return 1'b0;
			end
			return 1'b1;
		end
		if (r.sph && o.sph) begin
			reach = r.b[0] + o.b[0];
			if (reach <= 0)
				return 1'b0;
			return dist_sq(r.a, o.a) < reach * reach;
		end
		if (r.sph)
			return ball_touches_box(r, o);
		return ball_touches_box(o, r);
	endfunction

	function automatic bit predict_hit(query_t q);
		shape_t r;
		shape_t o;
		r = to_shape(anchor_zone);
		o = to_shape(q.zone);
		case (q.kind)
			KIND_POINT: return point_in(r, o.a);
			KIND_HOLDS: return encloses(r, o);
			KIND_MEETS: return touches(r, o);
			default:    return 1'b0;
		endcase
	endfunction

	function automatic coord_t draw_coord(longint base, int spread);
		case ($urandom_range(0, 9))
			0:       return coord_t'($urandom);
			1:       return $urandom_range(0, 1) ? C_MAX : C_MIN;
			default: return coord_t'(base + longint'($urandom_range(0, 2 * spread)) - spread);
		endcase
	endfunction

	function automatic coord_t draw_max(coord_t lo, int spread);
		if ($urandom_range(0, 9) == 0)
			return coord_t'($urandom);
		return coord_t'(widen(lo) + longint'($urandom_range(0, spread)));
	endfunction

	function automatic coord_t draw_radius(int spread);
		case ($urandom_range(0, 9))
			0:       return coord_t'($urandom);
			1:       return coord_t'(-longint'($urandom_range(1, spread)));
			2:       return CZ;
			default: return coord_t'($urandom_range(1, spread));
		endcase
	endfunction

	function automatic query_t draw_query(vec3_t mid, int spread);
		query_t q;
		int     pick;
		pick = $urandom_range(0, 12);
		case (pick % 3)
			0:       q.kind = KIND_POINT;
			1:       q.kind = KIND_HOLDS;
			default: q.kind = KIND_MEETS;
		endcase
		if (pick == 12)
			q.kind = KIND_NONE;
		q.zone.sph = 1'($urandom_range(0, 1));
		q.zone.ax  = draw_coord(mid[0], spread);
		q.zone.ay  = draw_coord(mid[1], spread);
		q.zone.az  = draw_coord(mid[2], spread);
		if (q.zone.sph) begin
			q.zone.bx = draw_radius(spread);
			q.zone.by = coord_t'($urandom);
			q.zone.bz = coord_t'($urandom);
		end else begin
			q.zone.bx = draw_max(q.zone.ax, spread);
			q.zone.by = draw_max(q.zone.ay, spread);
			q.zone.bz = draw_max(q.zone.az, spread);
		end
		return q;
	endfunction

	function automatic vec3_t zone_mid(zone_t z);
		vec3_t  m;
		shape_t s;
		s = to_shape(z);
		for (int i = 0; i < 3; i++)
			m[i] = s.sph ? s.a[i] : (s.a[i] + s.b[i]) / 2;
		return m;
	endfunction

	task automatic pick_anchor(int ph, output zone_t z, output int spread);
		vec3_t c;
		int    sz;
		sz = $urandom_range(1, 4096);
		spread = 2 * sz + 512;
		for (int i = 0; i < 3; i++)
			c[i] = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
		case (ph)
			0: begin
				z = '{1'b0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX};
				spread = 1 << 23;
			end
			1: begin
				z = '{1'b1, coord_t'(c[0]), coord_t'(c[1]), coord_t'(c[2]),
					coord_t'(-longint'(sz)), coord_t'($urandom), coord_t'($urandom)};
			end
			2: begin
				z = '{1'b0,
					coord_t'(c[0] + $urandom_range(0, sz)),
					coord_t'(c[1] + $urandom_range(0, sz)),
					coord_t'(c[2] + $urandom_range(0, sz)),
					coord_t'(c[0] - $urandom_range(0, sz)),
					coord_t'(c[1] - $urandom_range(0, sz)),
					coord_t'(c[2] - $urandom_range(0, sz))};
			end
			3: begin
				z = '{1'b1, C_MAX, C_MAX, C_MAX, C_MAX, coord_t'($urandom), coord_t'($urandom)};
				spread = 1 << 23;
			end
			default: begin
				if ($urandom_range(0, 1)) begin
					z = '{1'b1, coord_t'(c[0]), coord_t'(c[1]), coord_t'(c[2]),
						coord_t'(sz), coord_t'($urandom), coord_t'($urandom)};
				end else begin
					z = '{1'b0,
						coord_t'(c[0] - $urandom_range(0, sz)),
						coord_t'(c[1] - $urandom_range(0, sz)),
						coord_t'(c[2] - $urandom_range(0, sz)),
						coord_t'(c[0] + $urandom_range(0, sz)),
						coord_t'(c[1] + $urandom_range(0, sz)),
						coord_t'(c[2] + $urandom_range(0, sz))};
				end
			end
		endcase
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic load_anchor(zone_t z);
		cfg_data_t junk;
		junk = cfg_data_t'($urandom);
		write_reg(CFG_IS_SPHERE, {junk[COORD_BITS-1:1], z.sph});
		write_reg(CFG_A_X, cfg_data_t'(z.ax));
		write_reg(CFG_A_Y, cfg_data_t'(z.ay));
		write_reg(CFG_A_Z, cfg_data_t'(z.az));
		write_reg(CFG_B_X, cfg_data_t'(z.bx));
		write_reg(CFG_B_Y, cfg_data_t'(z.by));
		write_reg(CFG_B_Z, cfg_data_t'(z.bz));
		write_reg(CFG_UNUSED, junk);
		cfg_we <= 1'b0;
		anchor_zone = z;
		anchors_loaded++;
	endtask

	task automatic push_query(query_t q, bit known, bit known_val);
		in_valid        <= 1'b1;
		kind            <= q.kind;
		other_is_sphere <= q.zone.sph;
		other_a_x       <= q.zone.ax;
		other_a_y       <= q.zone.ay;
		other_a_z       <= q.zone.az;
		other_b_x       <= q.zone.bx;
		other_b_y       <= q.zone.by;
		other_b_z       <= q.zone.bz;
		do @(posedge clk); while (!in_ready);
		pending_hits.push_back(known ? known_val : predict_hit(q));
		kind_count[q.kind]++;
	endtask

	task automatic sender_gap();
		if (!calm) begin
			if (tx_left == 0) begin
				tx_choppy = ($urandom_range(0, 2) != 0);
				tx_left   = $urandom_range(20, 80);
			end
			tx_left--;
			if (tx_choppy && $urandom_range(0, 3) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_hits.size() != 0);
		repeat (LATENCY) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("aabb_sphere_overlap_test: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_hits.size() == 0) begin
				$error("hit: no result expected, got %0b", hit);
				errors++;
			end else begin
				want_hit = pending_hits.pop_front();
				if (hit !== want_hit) begin
					$error("hit: expected %0b, got %0b", want_hit, hit);
					errors++;
				end
				results_seen++;
				if (hit === 1'b1)
					hits_seen++;
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		bit rx_choppy;
		int rx_left;
		rx_choppy = 1'b0;
		rx_left   = 0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_left == 0) begin
				rx_choppy = ($urandom_range(0, 2) != 0);
				rx_left   = $urandom_range(20, 80);
			end
			rx_left--;
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 1'b0;
			end else if (!calm && rx_choppy && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		int    cur_sel;
		int    spread;
		zone_t z;
		vec3_t mid;
		cur_sel = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (int'(dir_rows[i].sel) != cur_sel) begin
				drain();
				load_anchor(dir_anchors[dir_rows[i].sel]);
				cur_sel = int'(dir_rows[i].sel);
			end
			push_query(dir_rows[i].q, dir_rows[i].known, dir_rows[i].val);
			sender_gap();
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			pick_anchor(ph, z, spread);
			load_anchor(z);
			mid  = zone_mid(z);
			calm = (ph == NUM_PHASES - 1);
			if (ph == 2) begin
				// back up the pipeline while the receiver holds off
				hold_out = 1'b1;
				repeat (HOLD_ITEMS) push_query(draw_query(mid, spread), 1'b0, 1'b0);
			end
			repeat (PHASE_ITEMS) begin
				push_query(draw_query(mid, spread), 1'b0, 1'b0);
				sender_gap();
			end
		end

		drain();
		repeat (LATENCY + 5) @(posedge clk);
		if (pending_hits.size() != 0) begin
			$error("hit: %0d results never arrived", pending_hits.size());
			errors++;
		end
		$display("checked %0d queries across %0d reference regions", results_seen,
			anchors_loaded + 1);
		$display("point %0d, containment %0d, intersection %0d, unused kind %0d; %0d hits",
			kind_count[KIND_POINT], kind_count[KIND_HOLDS], kind_count[KIND_MEETS],
			kind_count[KIND_NONE], hits_seen);
		if (errors == 0) begin
			$display("aabb_sphere_overlap_test: match");
		end else begin
			$display("aabb_sphere_overlap_test: mismatch");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/asot_pkg.sv
src/aabb_sphere_overlap_test.sv
tb/tb_aabb_sphere_overlap_test.sv
